// ----- design/dss_pkg.sv -----
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants for the dual stack in one shared store.
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int DEPTH  = 8;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// request codes
	localparam logic [2:0] REQ_PUSH_LO = 3'd0;
	localparam logic [2:0] REQ_PUSH_HI = 3'd1;
	localparam logic [2:0] REQ_POP_LO  = 3'd2;
	localparam logic [2:0] REQ_POP_HI  = 3'd3;
	localparam logic [2:0] REQ_PEEK_LO = 3'd4;
	localparam logic [2:0] REQ_PEEK_HI = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0]               status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} dp_cmd_t;

endpackage

// ----- design/dss_ram.sv -----
// ----------------------------------------------------------------------------
// dss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/dss_ctrl.sv -----
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: capture a request, execute it, present the response.
// ----------------------------------------------------------------------------
module dss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output dss_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_RESP);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);

endmodule

// ----- design/dss_dp.sv -----
// ----------------------------------------------------------------------------
// dss_dp
// Datapath: stack counters, store addressing and response formation.
// ----------------------------------------------------------------------------
module dss_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  dss_pkg::dp_cmd_t cmd,
	input  dss_pkg::req_t    req,
	output dss_pkg::rsp_t    rsp
);

	localparam logic [dss_pkg::ADDR_W-1:0] TOP_ADDR = dss_pkg::ADDR_W'(dss_pkg::DEPTH - 1);
	localparam logic [dss_pkg::CNT_W:0]    FULL_CNT = (dss_pkg::CNT_W + 1)'(dss_pkg::DEPTH);

	dss_pkg::req_t              req_q;
	logic [dss_pkg::CNT_W-1:0]  lower_q;
	logic [dss_pkg::CNT_W-1:0]  upper_q;
	logic [1:0]                 status_q;
	logic                       rd_sel_q;

	logic                       full;
	logic [dss_pkg::CNT_W-1:0]  lower_d;
	logic [dss_pkg::CNT_W-1:0]  upper_d;
	logic [1:0]                 status_d;
	logic                       rd_sel_d;
	logic                       wr_en;
	logic [dss_pkg::ADDR_W-1:0] wr_addr;
	logic                       rd_en;
	logic [dss_pkg::ADDR_W-1:0] rd_addr;
	logic [dss_pkg::DATA_W-1:0] rd_data;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	assign full = ({1'b0, lower_q} + {1'b0, upper_q}) >= FULL_CNT;

	always_comb begin
		lower_d  = lower_q;
		upper_d  = upper_q;
		status_d = dss_pkg::ST_OK;
		rd_sel_d = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = lower_q[dss_pkg::ADDR_W-1:0];
		rd_addr  = lower_q[dss_pkg::ADDR_W-1:0] - 1'b1;
		case (req_q.req_type) inside
			dss_pkg::REQ_PUSH_LO: begin
				if (full) begin
					status_d = dss_pkg::ST_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					lower_d = lower_q + 1'b1;
				end
			end
			dss_pkg::REQ_PUSH_HI: begin
				wr_addr = TOP_ADDR - upper_q[dss_pkg::ADDR_W-1:0];
				if (full) begin
					status_d = dss_pkg::ST_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					upper_d = upper_q + 1'b1;
				end
			end
			dss_pkg::REQ_POP_LO, dss_pkg::REQ_PEEK_LO: begin
				if (lower_q == '0) begin
					status_d = dss_pkg::ST_UNDERFLOW;
				end else begin
					rd_sel_d = 1'b1;
					if (req_q.req_type == dss_pkg::REQ_POP_LO) begin
						lower_d = lower_q - 1'b1;
					end
				end
			end
			dss_pkg::REQ_POP_HI, dss_pkg::REQ_PEEK_HI: begin
				rd_addr = TOP_ADDR - (upper_q[dss_pkg::ADDR_W-1:0] - 1'b1);
				if (upper_q == '0) begin
					status_d = dss_pkg::ST_UNDERFLOW;
				end else begin
					rd_sel_d = 1'b1;
					if (req_q.req_type == dss_pkg::REQ_POP_HI) begin
						upper_d = upper_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign rd_en = cmd.exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= '0;
			upper_q  <= '0;
			status_q <= dss_pkg::ST_OK;
			rd_sel_q <= 1'b0;
		end else if (cmd.exec) begin
			lower_q  <= lower_d;
			upper_q  <= upper_d;
			status_q <= status_d;
			rd_sel_q <= rd_sel_d;
		end
	end

	dss_ram #(
		.WIDTH(dss_pkg::DATA_W),
		.DEPTH(dss_pkg::DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en && cmd.exec),
		.wr_addr(wr_addr),
		.wr_data(req_q.push_value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rsp.read_value = rd_sel_q ? rd_data : '0;
	assign rsp.status     = status_q;

endmodule

// ----- design/dual_stack_shared_memory.sv -----
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// Two LIFO stacks sharing one word store: stack one grows up from entry 0,
// stack two grows down from the top entry.
// ----------------------------------------------------------------------------
//
//   channel   | ports                  | transaction taken when
//   ----------+------------------------+-----------------------------
//   request   | start, busy, req       | rising edge, start=1, busy=0
//   response  | done, rsp              | rising edge with done=1
//
// Every transaction runs through capture, execute (counter update,
// store write or store read issued) and response. The store's registered read
// port sets the response cycle. A new request can be taken the cycle after
// done. Reset clears both stack counters at once; the store contents stay
// undefined until pushed, and no clearing pass runs. The receiver cannot
// stall: each response shows for exactly one cycle with done high.
//
module dual_stack_shared_memory (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dss_pkg::req_t req,
	output logic          done,
	output dss_pkg::rsp_t rsp
);

	// command bundle from the sequencer to the datapath
	dss_pkg::dp_cmd_t cmd;

	// Sequence each transaction: capture, execute, respond.
	dss_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	// Hold the counters and the store; form status and read data.
	dss_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

// ----- sim/dual_stack_shared_memory_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_tb
// Self-checking bench for the two stacks in one shared word store. A planner
// queues a short directed set, then fill, drain, mixed and noise bursts.
// A clocked driver feeds them through start/busy with random gaps. A stack
// predictor forecasts each reply, and a monitor checks every done strobe
// field by field against the oldest forecast.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_tb;

	import dss_pkg::*;

	// codes the block must ignore
	localparam logic [2:0] REQ_RSVD_A = 3'd6;
	localparam logic [2:0] REQ_RSVD_B = 3'd7;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_MAX   = 10;
	localparam int PLAN_TARGET  = 520;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	dual_stack_shared_memory u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Stack predictor: private copy of the shared store and both fill counts.
	// ------------------------------------------------------------------------
	logic signed [DATA_W-1:0] stack_words [DEPTH];
	int lower_fill = 0;
	int upper_fill = 0;

	// Forecast the reply to one request and advance the predicted state.
	function automatic rsp_t predict_stack_op(req_t r);
		rsp_t o;
		int   pos;
		o.read_value = '0;
		o.status     = ST_OK;
		case (r.req_type) inside
			REQ_PUSH_LO, REQ_PUSH_HI: begin
				if (lower_fill + upper_fill >= DEPTH) begin
					o.status = ST_OVERFLOW;
				end else if (r.req_type == REQ_PUSH_LO) begin
					stack_words[lower_fill] = r.push_value;
					lower_fill++;
				end else begin
					upper_fill++;
					stack_words[DEPTH - upper_fill] = r.push_value;
				end
			end
			REQ_POP_LO, REQ_PEEK_LO: begin
				if (lower_fill == 0) begin
					o.status = ST_UNDERFLOW;
				end else begin
					pos          = lower_fill - 1;
					o.read_value = stack_words[pos];
					if (r.req_type == REQ_POP_LO)
						lower_fill = pos;
				end
			end
			REQ_POP_HI, REQ_PEEK_HI: begin
				if (upper_fill == 0) begin
					o.status = ST_UNDERFLOW;
				end else begin
					pos          = DEPTH - upper_fill;
					o.read_value = stack_words[pos];
					if (r.req_type == REQ_POP_HI)
						upper_fill--;
				end
			end
			default: ;	// unused codes: no change, zero reply
		endcase
		return o;
	endfunction

	rsp_t queued_replies [$];

	// ------------------------------------------------------------------------
	// Request planning. plan_lo / plan_hi only track occupancy so the bursts
	// can be shaped (fill to the brim, drain to empty); they never check.
	// ------------------------------------------------------------------------
	req_t pending_reqs [$];
	int   planned_items = 0;
	int   plan_lo       = 0;
	int   plan_hi       = 0;

	task automatic add_item(logic [2:0] kind, logic [DATA_W-1:0] value);
		req_t r;
		r.req_type   = kind;
		r.push_value = value;
		pending_reqs.push_back(r);
		planned_items++;
		case (kind)
			REQ_PUSH_LO: if (plan_lo + plan_hi < DEPTH) plan_lo++;
			REQ_PUSH_HI: if (plan_lo + plan_hi < DEPTH) plan_hi++;
			REQ_POP_LO:  if (plan_lo > 0) plan_lo--;
			REQ_POP_HI:  if (plan_hi > 0) plan_hi--;
			default: ;
		endcase
	endtask

	// Bias words toward the sign and all-ones/all-zeros corners.
	function automatic logic [DATA_W-1:0] any_word();
		case ($urandom_range(0, 9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return '0;
			3:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: hold a request while busy, retire it on the accepting edge, then
	// either idle for a while or present the next one. Gaps are mostly zero
	// or short, a few long, with occasional back-to-back bursts.
	// ------------------------------------------------------------------------
	int idle_left      = 0;
	int burst_left     = 0;
	int requests_taken = 0;

	function automatic int pick_idle();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		return $urandom_range(5, 24);
	endfunction

	always @(posedge clk) begin
		logic took;
		took = start && !busy;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			// forecast the reply at the edge that takes the transaction
			if (took) begin
				queued_replies.push_back(predict_stack_op(req));
				requests_taken++;
			end
			// a request still waiting on busy is held untouched
			if (!start || took) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req       <= pending_reqs.pop_front();
					start     <= 1'b1;
					idle_left = pick_idle();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every done strobe is one transaction, compared with the oldest
	// forecast. Also run the watchdog on cycles with no transaction at all.
	// ------------------------------------------------------------------------
	int mismatch_count = 0;
	int replies_seen   = 0;
	int seen_ok        = 0;
	int seen_overflow  = 0;
	int seen_underflow = 0;
	int stall_cycles   = 0;

	task automatic note_mismatch(string what, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t: %s expected %h got %h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			replies_seen++;
			if (queued_replies.size() == 0) begin
				note_mismatch("reply with nothing outstanding, read_value", 'x,
					rsp.read_value);
			end else begin
				want = queued_replies.pop_front();
				if (rsp.read_value !== want.read_value)
					note_mismatch("read_value", want.read_value, rsp.read_value);
				if (rsp.status !== want.status)
					note_mismatch("status", {30'd0, want.status}, {30'd0, rsp.status});
				case (want.status)
					ST_OVERFLOW:  seen_overflow++;
					ST_UNDERFLOW: seen_underflow++;
					default:      seen_ok++;
				endcase
			end
		end

		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
				stall_cycles, queued_replies.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus plan, reset, and end of run.
	// ------------------------------------------------------------------------
	initial begin
		int         roll;
		logic [2:0] kind;
		logic       peek;

		// Directed: underflow on both empty stacks, pop and peek.
		add_item(REQ_PEEK_LO, 32'h1234_5678);
		add_item(REQ_PEEK_HI, 32'hFFFF_FFFF);
		add_item(REQ_POP_LO,  32'h8000_0000);
		add_item(REQ_POP_HI,  32'h7FFF_FFFF);
		// Unused codes must be ignored, even with a word attached.
		add_item(REQ_RSVD_A, 32'hDEAD_BEEF);
		add_item(REQ_RSVD_B, 32'hFFFF_FFFF);
		// Fill the store from both ends with corner words.
		add_item(REQ_PUSH_LO, 32'h7FFF_FFFF);
		add_item(REQ_PUSH_HI, 32'h8000_0000);
		add_item(REQ_PUSH_LO, 32'h0000_0000);
		add_item(REQ_PUSH_HI, 32'hFFFF_FFFF);
		add_item(REQ_PUSH_LO, 32'h5555_5555);
		add_item(REQ_PUSH_HI, 32'hAAAA_AAAA);
		add_item(REQ_PUSH_LO, 32'h0000_0001);
		add_item(REQ_PUSH_HI, 32'hFFFF_FFFE);
		// Full: both pushes overflow and must not clobber anything.
		add_item(REQ_PUSH_LO, 32'h0BAD_0BAD);
		add_item(REQ_PUSH_HI, 32'h0BAD_0BAD);
		// Read back across the meeting point.
		add_item(REQ_PEEK_LO, '0);
		add_item(REQ_PEEK_HI, '0);
		add_item(REQ_POP_LO,  '0);
		add_item(REQ_POP_HI,  '0);
		add_item(REQ_POP_LO,  '0);
		add_item(REQ_PEEK_HI, '0);

		// Random part: mostly well-formed fill and drain runs, plus some
		// mixed traffic and a little noise with the unused codes.
		while (planned_items < PLAN_TARGET) begin
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				while (plan_lo + plan_hi < DEPTH)
					add_item($urandom_range(0, 1) ? REQ_PUSH_HI : REQ_PUSH_LO, any_word());
				if ($urandom_range(0, 1))
					add_item($urandom_range(0, 1) ? REQ_PUSH_HI : REQ_PUSH_LO, any_word());
			end else if (roll < 7) begin
				while (plan_lo + plan_hi > 0) begin
					peek = ($urandom_range(0, 3) == 0);
					if (plan_lo == 0 || (plan_hi != 0 && $urandom_range(0, 1)))
						kind = peek ? REQ_PEEK_HI : REQ_POP_HI;
					else
						kind = peek ? REQ_PEEK_LO : REQ_POP_LO;
					add_item(kind, any_word());
				end
				if ($urandom_range(0, 1))
					add_item(3'($urandom_range(REQ_POP_LO, REQ_PEEK_HI)), any_word());
			end else if (roll < 9) begin
				repeat ($urandom_range(5, 15))
					add_item(3'($urandom_range(REQ_PUSH_LO, REQ_PEEK_HI)), any_word());
			end else begin
				repeat ($urandom_range(2, 8))
					add_item(3'($urandom_range(REQ_PUSH_LO, REQ_RSVD_B)), any_word());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Sample on the falling edge so the driver's updates have settled.
		while (pending_reqs.size() != 0 || start || queued_replies.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests and %0d replies: %0d ok, %0d overflow, %0d underflow",
			requests_taken, replies_seen, seen_ok, seen_overflow, seen_underflow);
		$display("%0d field mismatches", mismatch_count);
		if (mismatch_count == 0 && queued_replies.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
